[src/lifo_stack_with_indexed_access_macros.svh]
// assertion macros for the lifo stack with indexed access
// no dependencies; included by the top level only
`ifndef LIFO_STACK_WITH_INDEXED_ACCESS_MACROS_SVH
`define LIFO_STACK_WITH_INDEXED_ACCESS_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define LSIA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lsia assertion failed");
// next-cycle implication
`define LSIA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lsia assertion failed");
`else
`define LSIA_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define LSIA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[src/lsia_pkg.sv]
// shared types and constants for the lifo stack with indexed access
// no dependencies
`timescale 1ns / 1ps

package lsia_pkg;

    localparam int DEPTH_DEFAULT = 8;
    localparam int WORD_W        = 32;
    localparam int POS_W         = 3;
    localparam int COUNT_W       = 4;

    typedef enum logic [1:0] {
        REQ_PUSH   = 2'd0,
        REQ_POP    = 2'd1,
        REQ_PEEK   = 2'd2,
        REQ_CHANGE = 2'd3
    } t_req_kind;

    typedef enum logic [1:0] {
        ERR_OK    = 2'd0,
        ERR_FULL  = 2'd1,
        ERR_EMPTY = 2'd2
    } t_err;

    typedef struct packed {
        t_req_kind                 req_type;
        logic [POS_W-1:0]          position;
        logic signed [WORD_W-1:0]  value;
    } t_req;

    typedef struct packed {
        logic signed [WORD_W-1:0]  data;
        t_err                      error;
        logic [COUNT_W-1:0]        count;
        logic                      is_empty;
        logic                      is_full;
    } t_rsp;

    typedef struct packed {
        logic clear_en;
        logic accept;
        logic exec;
        logic load;
    } t_ctrl_cmd;

    typedef struct packed {
        logic clear_done;
        logic out_busy;
    } t_dp_status;

endpackage

[src/lsia_ctrl.sv]
// control state machine: clearing pass, accept, execute, load result
// depends on lsia_pkg
`timescale 1ns / 1ps

module lsia_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  lsia_pkg::t_dp_status  i_status,
    output lsia_pkg::t_ctrl_cmd   o_cmd
);
    import lsia_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_EXEC  = 4'b0100,
        S_LOAD  = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (i_status.clear_done) n_state = S_IDLE;
            S_IDLE:  if (i_in_valid) n_state = S_EXEC;
            S_EXEC:  n_state = S_LOAD;
            S_LOAD:  if (!i_status.out_busy) n_state = S_IDLE;
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready     = (r_state == S_IDLE);
    assign o_cmd.clear_en = (r_state == S_CLEAR);
    assign o_cmd.accept   = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.exec     = (r_state == S_EXEC);
    assign o_cmd.load     = (r_state == S_LOAD) && !i_status.out_busy;

endmodule

[src/lsia_dp.sv]
// datapath: stack store, fill count, request and result registers
// depends on lsia_pkg
`timescale 1ns / 1ps

module lsia_dp #(
    parameter int DEPTH = lsia_pkg::DEPTH_DEFAULT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  lsia_pkg::t_ctrl_cmd   i_cmd,
    output lsia_pkg::t_dp_status  o_status,
    input  lsia_pkg::t_req        i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output lsia_pkg::t_rsp        o_out_data
);
    import lsia_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WORD_W-1:0]        r_mem [DEPTH];
    logic signed [WORD_W-1:0] r_rd;
    logic [AW-1:0]            r_clr_addr;
    t_req                     r_req;
    logic [CW-1:0]            r_count;
    logic [CW-1:0]            n_count;
    t_err                     r_err;
    t_err                     n_err;
    logic                     r_use_rd;
    logic                     n_use_rd;
    logic                     r_out_valid;
    t_rsp                     r_out;

    logic                     op_we;
    logic [AW-1:0]            op_waddr;
    logic [WORD_W-1:0]        op_wdata;
    logic                     op_re;
    logic [AW-1:0]            op_raddr;

    logic                     mem_we;
    logic [AW-1:0]            mem_waddr;
    logic [WORD_W-1:0]        mem_wdata;

    logic [AW+2:0]            pos_ext;
    logic [AW-1:0]            pos_addr;
    logic                     pos_ok;
    logic [CW-1:0]            cnt_dec;
    logic                     is_full;
    logic                     is_empty;
    logic [CW+3:0]            cnt_ext;

    assign pos_ext  = {AW'(0), r_req.position};
    assign pos_addr = pos_ext[AW-1:0];
    assign pos_ok   = pos_ext < (AW+3)'(DEPTH);
    assign cnt_dec  = r_count - CW'(1);
    assign is_full  = (r_count == CW'(DEPTH));
    assign is_empty = (r_count == CW'(0));

    // decode of the held request
    always_comb begin
        op_we    = 1'b0;
        op_waddr = pos_addr;
        op_wdata = r_req.value;
        op_re    = 1'b0;
        op_raddr = pos_addr;
        n_count  = r_count;
        n_err    = ERR_OK;
        n_use_rd = 1'b0;
        unique case (r_req.req_type)
            REQ_PUSH: begin
                if (is_full) begin
                    n_err = ERR_FULL;
                end else begin
                    op_we    = 1'b1;
                    op_waddr = r_count[AW-1:0];
                    n_count  = r_count + CW'(1);
                end
            end
            REQ_POP: begin
                if (is_empty) begin
                    n_err = ERR_EMPTY;
                end else begin
                    op_we    = 1'b1;
                    op_waddr = cnt_dec[AW-1:0];
                    op_wdata = '0;
                    op_re    = 1'b1;
                    op_raddr = cnt_dec[AW-1:0];
                    n_use_rd = 1'b1;
                    n_count  = cnt_dec;
                end
            end
            REQ_PEEK: begin
                if (is_empty) begin
                    n_err = ERR_EMPTY;
                end else if (pos_ok) begin
                    op_re    = 1'b1;
                    n_use_rd = 1'b1;
                end
            end
            REQ_CHANGE: begin
                op_we = pos_ok;
            end
            default: begin
                n_err = ERR_OK;
            end
        endcase
    end

    // write port shared by the clearing pass and requests
    always_comb begin
        if (i_cmd.clear_en) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_addr;
            mem_wdata = '0;
        end else begin
            mem_we    = i_cmd.exec && op_we;
            mem_waddr = op_waddr;
            mem_wdata = op_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && op_re) begin
            r_rd <= r_mem[op_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clear_en) begin
            r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_req <= i_in_data;
        end
        if (i_cmd.exec) begin
            r_err    <= n_err;
            r_use_rd <= n_use_rd;
        end
    end

    assign cnt_ext = {4'b0000, r_count};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out.data     <= r_use_rd ? r_rd : '0;
            r_out.error    <= r_err;
            r_out.count    <= cnt_ext[COUNT_W-1:0];
            r_out.is_empty <= is_empty;
            r_out.is_full  <= is_full;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_status.clear_done = (r_clr_addr == AW'(DEPTH - 1));
    assign o_status.out_busy   = r_out_valid && !i_out_ready;
    assign o_out_valid         = r_out_valid;
    assign o_out_data          = r_out;

endmodule

[src/lifo_stack_with_indexed_access.sv]
// top level of the lifo stack with indexed access
// depends on lsia_pkg, lsia_ctrl, lsia_dp and the assertion macro header
//
// usage
//   input channel  i_in_valid / o_in_ready / i_in_data: one request per
//   transaction (push, pop, peek at position, change at position)
//   output channel o_out_valid / i_out_ready / o_out_data: one result per
//   request with data, error code, entry count and empty / full flags
// sequence
//   a request is taken in the idle state, worked on the stack store in the
//   execute state and its result loaded into the output register in the
//   load state; no new request is taken before that load, as set by the
//   registered read port of the stack store, which holds DEPTH words
// reset
//   after i_rst_n is released a clearing pass zeroes the store, one entry
//   a cycle; o_in_ready stays low meanwhile
// stalls
//   the output register holds its result until taken; the next request is
//   still taken and worked, then waits until the output register frees
`timescale 1ns / 1ps
`include "lifo_stack_with_indexed_access_macros.svh"

module lifo_stack_with_indexed_access #(
    parameter int DEPTH = lsia_pkg::DEPTH_DEFAULT
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  lsia_pkg::t_req  i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output lsia_pkg::t_rsp  o_out_data
);
    import lsia_pkg::*;

    // command and status between controller and datapath
    t_ctrl_cmd  ctrl_cmd;
    t_dp_status dp_status;

    // sequencer: clearing pass, then accept / execute / load per request
    lsia_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (dp_status),
        .o_cmd      (ctrl_cmd)
    );

    // store, fill count and result register
    lsia_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (ctrl_cmd),
        .o_status    (dp_status),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // one request in flight: no new transaction straight after one is taken
    `LSIA_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)
    // a result is only loaded while the output register can take it
    `LSIA_ASSERT_NOW(a_load_free, i_clk, i_rst_n, ctrl_cmd.load, !dp_status.out_busy)
    // no transaction accepted during the clearing pass
    `LSIA_ASSERT_NOW(a_clear_blocks, i_clk, i_rst_n, ctrl_cmd.clear_en, !o_in_ready)
    // an empty result carries a zero count and never a full refusal
    `LSIA_ASSERT_NOW(a_empty_flags, i_clk, i_rst_n, o_out_valid && o_out_data.is_empty,
        (o_out_data.count == 4'd0) && !o_out_data.is_full && (o_out_data.error != ERR_FULL))

endmodule
